// File: src/bkms_pkg.sv
// shared types, request codes and controller states of the bottom-k minhash sketch
package bkms_pkg;

	localparam int SKETCH_SIZE_DEF = 256;
	localparam int NGRAM_LEN_DEF   = 4;

	localparam logic [1:0] REQ_DATA  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic [31:0] entry_hash;
		logic        entry_valid;
		logic [8:0]  sketch_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SRCH_CMP,
		ST_DECIDE,
		ST_SHIFT,
		ST_SH_WR,
		ST_RD_DATA
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic clear;
		logic rd_issue;
		logic srch_rd;
		logic srch_cmp;
		logic sh_init;
		logic sh_rd;
		logic sh_wr;
		logic put;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic win_full;
		logic lo_lt_hi;
		logic skip;
		logic idx_gt_lo;
		logic out_free;
	} sts_t;

endpackage

// File: src/bottom_k_ngram_minhash_sketch_core.sv
// top level of the bottom-k n-gram minhash sketch: controller plus datapath
// read request: entry read into a register, then into the result register; held in the read
// state while the previous result beat waits for out_ready, next request taken back in idle
// data byte: only the window shifts while it fills; once full, search probes one at a time
// (at most clog2(SKETCH_SIZE+1)), a close of the search and a decide, which drops a duplicate
// or a hash above a full sketch; else entries move up (at most SKETCH_SIZE-1), then insert
module bottom_k_ngram_minhash_sketch_core #(
	parameter int SKETCH_SIZE = bkms_pkg::SKETCH_SIZE_DEF,
	parameter int NGRAM_LEN   = bkms_pkg::NGRAM_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bkms_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bkms_pkg::rsp_t out_data
);
	import bkms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bkms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (in_data.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	bkms_dp #(
		.SKETCH_SIZE (SKETCH_SIZE),
		.NGRAM_LEN   (NGRAM_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: src/bkms_dp.sv
// datapath: byte window, hash, sorted sketch memory, search and shift registers, result register
module bkms_dp #(
	parameter int SKETCH_SIZE = bkms_pkg::SKETCH_SIZE_DEF,
	parameter int NGRAM_LEN   = bkms_pkg::NGRAM_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bkms_pkg::req_t in_data,
	input  bkms_pkg::cmd_t cmd,
	output bkms_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output bkms_pkg::rsp_t out_data
);
	import bkms_pkg::*;

	localparam int NEED      = NGRAM_LEN - 1;
	localparam int WIN_BYTES = (NEED > 0) ? NEED : 1;
	localparam int WIN_W     = 8 * WIN_BYTES;
	localparam int FILL_W    = (NGRAM_LEN > 2) ? $clog2(NGRAM_LEN) : 1;
	localparam int CNT_W     = $clog2(SKETCH_SIZE + 1);
	localparam int AW        = (SKETCH_SIZE > 1) ? $clog2(SKETCH_SIZE) : 1;
	localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NEED);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(SKETCH_SIZE);
	localparam logic [CNT_W-1:0]  TOP_FULL  = CNT_W'(SKETCH_SIZE - 1);

	logic [31:0]       mem [SKETCH_SIZE];
	logic [WIN_W-1:0]  win_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       hash_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic              dup_q;
	logic [CNT_W-1:0]  idx_q;
	logic [31:0]       rdata_q;
	logic              rd_valid_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [31:0]       h_win;
	logic [31:0]       new_hash;
	logic [WIN_W+7:0]  win_sh;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic              full;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [31:0]       mem_wdata;
	logic              idx_in_range;

	// hash of the window, oldest byte first, then the new byte
	always_comb begin
		h_win = '0;
		for (int k = NEED; k > 0; k--) begin
			h_win = {h_win[26:0], h_win[31:27]} ^ {24'd0, win_q[8*(k-1) +: 8]};
		end
		new_hash = {h_win[26:0], h_win[31:27]} ^ {24'd0, in_data.data_byte};
	end

	assign win_sh       = {win_q, in_data.data_byte};
	assign full         = (cnt_q == CNT_MAX);
	assign mid_sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid          = mid_sum[CNT_W:1];
	assign idx_in_range = (CMP_W'(in_data.read_index) < CMP_W'(cnt_q));

	assign sts.win_full  = (fill_q == FILL_FULL);
	assign sts.lo_lt_hi  = (lo_q < hi_q);
	assign sts.skip      = dup_q || (full && (lo_q == CNT_MAX));
	assign sts.idx_gt_lo = (idx_q > lo_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		mem_re    = cmd.rd_issue || cmd.srch_rd || cmd.sh_rd;
		mem_raddr = AW'(idx_q - 1'b1);
		if (cmd.rd_issue) begin
			mem_raddr = AW'(in_data.read_index);
		end else if (cmd.srch_rd) begin
			mem_raddr = AW'(mid);
		end
		mem_we    = cmd.sh_wr || cmd.put;
		mem_waddr = AW'(idx_q);
		mem_wdata = rdata_q;
		if (cmd.put) begin
			mem_waddr = AW'(lo_q);
			mem_wdata = hash_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				win_q  <= '0;
				fill_q <= '0;
				cnt_q  <= '0;
			end
			if (cmd.take_byte) begin
				win_q <= win_sh[WIN_W-1:0];
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.put && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			hash_q <= new_hash;
			lo_q   <= '0;
			hi_q   <= cnt_q;
			dup_q  <= 1'b0;
		end
		if (cmd.srch_cmp) begin
			if (rdata_q < hash_q) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
			end
			dup_q <= dup_q | (rdata_q == hash_q);
		end
		if (cmd.sh_init) begin
			idx_q <= full ? TOP_FULL : cnt_q;
		end
		if (cmd.sh_wr) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.rd_issue) begin
			rd_valid_q <= idx_in_range;
		end
		if (cmd.out_load) begin
			out_q.entry_hash   <= rd_valid_q ? rdata_q : 32'd0;
			out_q.entry_valid  <= rd_valid_q;
			out_q.sketch_count <= 9'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/bkms_ctrl.sv
// controller: request decode, binary search, shift and insert sequencing, read return
module bkms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     req_type,
	input  bkms_pkg::sts_t sts,
	output bkms_pkg::cmd_t cmd
);
	import bkms_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_DATA && sts.win_full) begin
						state_d = ST_SRCH;
					end else if (req_type == REQ_READ) begin
						state_d = ST_RD_DATA;
					end
				end
			end
			ST_SRCH: begin
				state_d = sts.lo_lt_hi ? ST_SRCH_CMP : ST_DECIDE;
			end
			ST_SRCH_CMP: begin
				state_d = ST_SRCH;
			end
			ST_DECIDE: begin
				state_d = sts.skip ? ST_IDLE : ST_SHIFT;
			end
			ST_SHIFT: begin
				state_d = sts.idx_gt_lo ? ST_SH_WR : ST_IDLE;
			end
			ST_SH_WR: begin
				state_d = ST_SHIFT;
			end
			ST_RD_DATA: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take_byte = accept && (req_type == REQ_DATA);
				cmd.rd_issue  = accept && (req_type == REQ_READ);
				cmd.clear     = accept && (req_type == REQ_START);
			end
			ST_SRCH: begin
				cmd.srch_rd = sts.lo_lt_hi;
			end
			ST_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
			end
			ST_DECIDE: begin
				cmd.sh_init = !sts.skip;
			end
			ST_SHIFT: begin
				cmd.sh_rd = sts.idx_gt_lo;
				cmd.put   = !sts.idx_gt_lo;
			end
			ST_SH_WR: begin
				cmd.sh_wr = 1'b1;
			end
			ST_RD_DATA: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: dv/bottom_k_ngram_minhash_sketch_core_tb.sv
// testbench of the bottom-k n-gram minhash sketch core: segment streams checked against an in-bench sketch
module bottom_k_ngram_minhash_sketch_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bkms_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WIN_BITS    = 8 * (NGRAM_LEN_DEF - 1);
	localparam int RAND_ITEMS  = 1500;
	localparam int TAIL_CYCLES = 2 * SKETCH_SIZE_DEF + 64;
	localparam int CYCLE_LIMIT = 4_000_000;

	class sketch_scoreboard;
		logic [WIN_BITS-1:0] win;
		int                  fill;
		logic [31:0]         hashes [SKETCH_SIZE_DEF];
		int                  held;
		rsp_t                expected_reads [$];
		int                  mismatches;

		function new();
			win        = '0;
			fill       = 0;
			held       = 0;
			mismatches = 0;
		endfunction

		function logic [31:0] rotl5(logic [31:0] h);
			return {h[26:0], h[31:27]};
		endfunction

		function void insert_hash(logic [31:0] h);
			int pos;
			int i;
			pos = 0;
			while (pos < held && hashes[pos] < h)
				pos++;
			if (pos < held && hashes[pos] == h)
				return;
			if (held >= SKETCH_SIZE_DEF) begin
				if (pos >= SKETCH_SIZE_DEF)
					return;
				for (i = SKETCH_SIZE_DEF - 1; i > pos; i--)
					hashes[i] = hashes[i-1];
				hashes[pos] = h;
				return;
			end
			for (i = held; i > pos; i--)
				hashes[i] = hashes[i-1];
			hashes[pos] = h;
			held++;
		endfunction

		function void take_byte(logic [7:0] b);
			logic [31:0] h;
			int          k;
			h = 32'd0;
			if (fill >= NGRAM_LEN_DEF - 1) begin
				for (k = NGRAM_LEN_DEF - 2; k >= 0; k--)
					h = rotl5(h) ^ {24'd0, win[8*k +: 8]};
				h = rotl5(h) ^ {24'd0, b};
				insert_hash(h);
			end else begin
				fill++;
			end
			win = {win[WIN_BITS-9:0], b};
		endfunction

		// runs the sketch forward on one accepted beat
		function void note_req(req_t r);
			rsp_t e;
			case (r.req_type)
				REQ_DATA: take_byte(r.data_byte);
				REQ_READ: begin
					e.entry_valid  = (int'(r.read_index) < held);
					e.entry_hash   = e.entry_valid ? hashes[r.read_index] : 32'd0;
					e.sketch_count = 9'(held);
					expected_reads.insert(expected_reads.size(), e);
				end
				REQ_START: begin
					win  = '0;
					fill = 0;
					held = 0;
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_rsp(rsp_t got);
			rsp_t e;
			if (expected_reads.size() == 0) begin
				report($sformatf("unexpected read beat %h", got));
				return;
			end
			e = expected_reads.pop_front();
			if (got.entry_hash !== e.entry_hash)
				report($sformatf("entry_hash %h, want %h", got.entry_hash, e.entry_hash));
			if (got.entry_valid !== e.entry_valid)
				report($sformatf("entry_valid %b, want %b", got.entry_valid, e.entry_valid));
			if (got.sketch_count !== e.sketch_count)
				report($sformatf("sketch_count %0d, want %0d", got.sketch_count,
					e.sketch_count));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	int in_idle_pct   = 0;
	int out_stall_pct = 0;
	int cycles        = 0;

	sketch_scoreboard sb = new();

	bottom_k_ngram_minhash_sketch_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_rsp(out_data);
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	task automatic send_req(input logic [1:0] kind, input logic [7:0] b,
		input logic [7:0] idx);
		req_t r;
		r = '{req_type: kind, data_byte: b, read_index: idx};
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_req(r);
	endtask

	function automatic logic [7:0] pick_index();
		int c;
		c = sb.held;
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'($urandom);
			4, 5, 6, 7: return (c > 0) ? 8'($urandom_range(c - 1)) : 8'd0;
			8: return (c > 255) ? 8'hFF : 8'(c);
			default: return 8'hFF;
		endcase
	endfunction

	task automatic set_idling(input int phase);
		case (phase)
			0: begin
				in_idle_pct   = 0;
				out_stall_pct = 0;
			end
			1: begin
				in_idle_pct   = 66;
				out_stall_pct = 0;
			end
			2: begin
				in_idle_pct   = 0;
				out_stall_pct = 66;
			end
			default: begin
				in_idle_pct   = 7;
				out_stall_pct = 7;
			end
		endcase
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("bottom_k_ngram_minhash_sketch_core_tb: FAIL");
		$finish;
	end

	initial begin
		int             items;
		int             long_segs;
		int             seg_len;
		int             mode;
		int             roll;
		int             replay_pos;
		int             j;
		bit             long_seg;
		logic [1:0]     kind;
		logic [7:0]     b;
		logic [7:0]     seg_bytes [$];

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads on an empty sketch, window fill, duplicates, unused code, start
		set_idling(3);
		send_req(REQ_READ, 8'h00, 8'h00);
		send_req(REQ_READ, 8'hFF, 8'hFF);
		send_req(REQ_DATA, 8'h00, 8'hFF);
		send_req(REQ_DATA, 8'hFF, 8'h00);
		send_req(REQ_DATA, 8'h80, 8'h00);
		send_req(REQ_READ, 8'h00, 8'h00);
		send_req(REQ_DATA, 8'h01, 8'h00);
		repeat (5) send_req(REQ_DATA, 8'hFF, 8'h00);
		send_req(REQ_UNUSED, 8'hA5, 8'h5A);
		for (j = 0; j < 7; j++)
			send_req(REQ_READ, 8'h00, 8'(j));
		send_req(REQ_READ, 8'h00, 8'hFF);
		send_req(REQ_START, 8'hFF, 8'hFF);
		send_req(REQ_READ, 8'hFF, 8'h00);
		repeat (4) send_req(REQ_DATA, 8'h00, 8'h55);
		send_req(REQ_READ, 8'h00, 8'h00);

		items     = 0;
		long_segs = 0;
		while (items < RAND_ITEMS) begin
			set_idling(items * 4 / RAND_ITEMS);
			roll = $urandom_range(99);
			if (roll < 6) begin
				repeat ($urandom_range(8, 1)) begin
					kind = 2'($urandom_range(3));
					send_req(kind, 8'($urandom), pick_index());
					if (kind != REQ_UNUSED)
						items++;
				end
			end else begin
				long_seg = (long_segs < 2) && (roll < 12 || items > (long_segs + 1) * 600);
				if (long_seg)
					long_segs++;
				seg_len    = long_seg ? $urandom_range(380, 300) : $urandom_range(40);
				mode       = long_seg ? 0 : $urandom_range(2);
				replay_pos = 0;
				seg_bytes.delete();
				send_req(REQ_START, 8'($urandom), 8'($urandom));
				items++;
				for (j = 0; j < seg_len; j++) begin
					roll = $urandom_range(99);
					if (roll < 12) begin
						send_req(REQ_READ, 8'($urandom), pick_index());
						items++;
					end else if (roll < 15) begin
						send_req(REQ_UNUSED, 8'($urandom), 8'($urandom));
					end else begin
						case (mode)
							0: b = 8'($urandom);
							1: b = 8'($urandom_range(3));
							default: b = $urandom_range(1) ? 8'hFF : 8'h00;
						endcase
						// tail of a long segment repeats its head: duplicates on a full sketch
						if (long_seg && j >= seg_len - 40 && seg_bytes.size() > 60) begin
							b = seg_bytes[replay_pos];
							replay_pos++;
						end else begin
							seg_bytes.insert(seg_bytes.size(), b);
						end
						send_req(REQ_DATA, b, 8'($urandom));
						items++;
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (sb.expected_reads.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("bottom_k_ngram_minhash_sketch_core_tb: PASS");
		else
			$display("bottom_k_ngram_minhash_sketch_core_tb: FAIL");
		$finish;
	end

endmodule
